@@ design/pfx_pkg.sv @@
// Shared types, constants and character codes for the postfix evaluator.
package pfx_pkg;

    // Operand width and stack geometry.
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int LIMIT_W     = 5;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    // Character codes.
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_OVERFLOW  = 3'd1,
        STATUS_UNDERFLOW = 3'd2,
        STATUS_DIVZERO   = 3'd3,
        STATUS_HALTED    = 3'd4
    } status_t;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_DIVIDE,
        S_PUSH,
        S_RETOP,
        S_RETOP_WAIT,
        S_RESULT
    } state_t;

    // Divider states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX
    } div_state_t;

endpackage

@@ design/pfx_stack_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module pfx_stack_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pfx_divider.sv @@
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
module pfx_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pfx_pkg::DATA_W-1:0] dividend,
    input  logic [pfx_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [pfx_pkg::DATA_W-1:0] quotient,
    output logic [pfx_pkg::DATA_W-1:0] remainder
);
    import pfx_pkg::*;

    div_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] iter_reg, iter_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_q_reg, neg_q_next;
    logic                 neg_r_reg, neg_r_next;
    logic [DATA_W-1:0]    quotient_reg, quotient_next;
    logic [DATA_W-1:0]    remainder_reg, remainder_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    // Restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        iter_reg      <= iter_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        neg_q_reg     <= neg_q_next;
        neg_r_reg     <= neg_r_next;
        quotient_reg  <= quotient_next;
        remainder_reg <= remainder_next;
    end

    // Next state and datapath.
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        quotient_next  = quotient_reg;
        remainder_next = remainder_reg;
        done_next      = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    // Work on magnitudes; the most negative value maps to itself.
                    quo_next   = dividend[DATA_W-1] ? -dividend : dividend;
                    dvs_next   = divisor[DATA_W-1] ? -divisor : divisor;
                    rem_next   = '0;
                    neg_q_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
                    neg_r_next = dividend[DATA_W-1];
                    iter_next  = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (!diff[DATA_W])
                begin
                    rem_next = diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    state_next = DIV_FIX;
                end
            end
            DIV_FIX:
            begin
                // Quotient sign from both operands, remainder sign from the dividend.
                quotient_next  = neg_q_reg ? -quo_reg : quo_reg;
                remainder_next = neg_r_reg ? -rem_reg : rem_reg;
                done_next      = 1'b1;
                state_next     = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign done      = done_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

`ifndef SYNTH
    // A start is only honored while idle, so the done pulse is always isolated.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
    // The run phase always ends in the sign fix-up cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV_RUN && iter_reg == DIV_CNT_W'(DATA_W - 1)) |=> state_reg == DIV_FIX)
        else $error("divider skipped the sign fix-up");
    // Done is only raised out of the fix-up cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg) == DIV_FIX)
        else $error("divider done raised outside fix-up");
`endif

endmodule

@@ design/postfix_expression_evaluator_top.sv @@
// Top level of the postfix expression evaluator: sequencer, operand stack RAM and divider.
//
//  Channel   Signals                                  Direction  Beat carries
//  ------    -------------------------------------    ---------  ---------------------------
//  in        in_valid, in_ready, char_code            input      one character code
//  out       out_valid, out_ready, top_value,          output     top of stack, empty, status
//            stack_empty, status
//  cfg       cfg_we, cfg_wdata                        input      stack_limit register write
//
// A digit, a halted item or an underflow goes from accept through decode straight to result.
// Add, subtract, multiply and discarded pairs add an operand fetch and then a push or a
// new-top refetch; both wait on the registered read data of the operand RAM.
// Divide and remainder also wait for the 32-step iterative divider.
// Reset clears the entry count, the halt flag and the output valid flag and sets stack_limit
// to 10; the RAM is not cleared, since only written entries are ever read.
// One item is in work at a time; the next is accepted once the result is in the output
// register, and a stalled output holds the sequencer in its result state.
module postfix_expression_evaluator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   char_code,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           top_value,
    output logic                         stack_empty,
    output logic [2:0]                   status,
    input  logic                         cfg_we,
    input  logic [pfx_pkg::LIMIT_W-1:0]  cfg_wdata
);
    import pfx_pkg::*;

    state_t               state_reg, state_next;
    logic [7:0]           char_reg, char_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 halted_reg, halted_next;
    logic [DATA_W-1:0]    top_reg, top_next;
    logic [DATA_W-1:0]    result_reg, result_next;
    status_t              status_reg, status_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] top_value_reg, top_value_next;
    logic                 stack_empty_reg, stack_empty_next;
    status_t              status_out_reg, status_out_next;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [DATA_W-1:0]    mem_rdata;

    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    div_quotient;
    logic [DATA_W-1:0]    div_remainder;

    logic                 is_digit;
    logic                 stack_full;
    logic [CNT_W-1:0]     count_less1;
    logic [CNT_W-1:0]     count_less2;
    logic [DATA_W-1:0]    product;

    // Operand stack storage.
    pfx_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared divider for quotient and remainder.
    pfx_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mem_rdata),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Decode helpers.
    assign is_digit    = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
    assign stack_full  = (CMP_W'(count_reg) >= CMP_W'(limit_reg))
                      || (count_reg >= CNT_W'(STACK_DEPTH));
    assign count_less1 = count_reg - 1'b1;
    assign count_less2 = count_reg - CNT_W'(2);
    assign product     = mem_rdata * top_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        char_reg        <= char_next;
        top_reg         <= top_next;
        result_reg      <= result_next;
        status_reg      <= status_next;
        top_value_reg   <= top_value_next;
        stack_empty_reg <= stack_empty_next;
        status_out_reg  <= status_out_next;
    end

    // Sequencer: next state, RAM accesses and output loading.
    always_comb
    begin
        state_next       = state_reg;
        char_next        = char_reg;
        count_next       = count_reg;
        halted_next      = halted_reg;
        top_next         = top_reg;
        result_next      = result_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg;
        top_value_next   = top_value_reg;
        stack_empty_next = stack_empty_reg;
        status_out_next  = status_out_reg;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[ADDR_W-1:0];
        mem_wdata        = result_reg;
        mem_re           = 1'b0;
        mem_raddr        = count_less2[ADDR_W-1:0];
        div_start        = 1'b0;
        in_ready         = 1'b0;

        // The output beat leaves when the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    char_next   = char_code;
                    status_next = STATUS_OK;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (halted_reg)
                begin
                    status_next = STATUS_HALTED;
                    state_next  = S_RESULT;
                end
                else if (is_digit)
                begin
                    if (stack_full)
                    begin
                        status_next = STATUS_OVERFLOW;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        // Push the digit and keep it as the cached top.
                        mem_we     = 1'b1;
                        mem_wdata  = DATA_W'(char_reg - CHAR_ZERO);
                        top_next   = DATA_W'(char_reg - CHAR_ZERO);
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_RESULT;
                end
                else if (count_reg < CNT_W'(2))
                begin
                    status_next = STATUS_UNDERFLOW;
                    halted_next = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    // Fetch the left operand; the right one is the cached top.
                    mem_re     = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                count_next = count_less2;
                case (char_reg) inside
                    CHAR_PLUS:
                    begin
                        result_next = mem_rdata + top_reg;
                        state_next  = S_PUSH;
                    end
                    CHAR_MINUS:
                    begin
                        result_next = mem_rdata - top_reg;
                        state_next  = S_PUSH;
                    end
                    CHAR_STAR:
                    begin
                        result_next = product;
                        state_next  = S_PUSH;
                    end
                    CHAR_SLASH, CHAR_PERCENT:
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = STATUS_DIVZERO;
                            halted_next = 1'b1;
                            state_next  = S_RETOP;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIVIDE;
                        end
                    end
                    default:
                    begin
                        // Both operands are dropped and nothing is pushed.
                        state_next = S_RETOP;
                    end
                endcase
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    result_next = (char_reg == CHAR_SLASH) ? div_quotient : div_remainder;
                    state_next  = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (stack_full)
                begin
                    // Operands stay popped; the limit may have been lowered.
                    status_next = STATUS_OVERFLOW;
                    halted_next = 1'b1;
                    state_next  = S_RETOP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    top_next   = result_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RETOP:
            begin
                // Reload the cached top after a net pop of two entries.
                if (count_reg == '0)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = count_less1[ADDR_W-1:0];
                    state_next = S_RETOP_WAIT;
                end
            end
            S_RETOP_WAIT:
            begin
                top_next   = mem_rdata;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    stack_empty_next = (count_reg == '0);
                    top_value_next   = (count_reg == '0) ? '1 : top_reg;
                    status_out_next  = status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign stack_empty = stack_empty_reg;
    assign status      = status_out_reg;

`ifndef SYNTH
    // The entry count never goes beyond the physical stack depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count exceeds stack depth");
    // Halt is sticky.
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");
    // An empty stack always reports minus one as the top.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stack_empty_reg) |-> (top_value_reg == '1))
        else $error("empty stack reported with a top value other than minus one");
    // The RAM is written only by a push.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_DECODE || state_reg == S_PUSH))
        else $error("operand RAM written outside a push");
    // The divider never sees a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> (top_reg != '0))
        else $error("divider started with a zero divisor");
`endif

endmodule

@@ tb/postfix_expression_evaluator_top_tb.sv @@
// Self-checking testbench for the postfix expression evaluator with a stack-model scoreboard.
module postfix_expression_evaluator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pfx_pkg::*;

    // One result beat as the evaluator should report it.
    typedef struct packed {
        logic signed [31:0] top;
        logic               empty;
        status_t            st;
    } rpn_result_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [7:0]          char_code   = 8'd0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic signed [31:0]  top_value;
    logic                stack_empty;
    logic [2:0]          status;
    logic                cfg_we      = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wdata   = LIMIT_RESET;

    // Character beats waiting for the driver and results waiting for the monitor.
    logic [7:0]  pending_chars[$];
    rpn_result_t expected_results[$];
    rpn_result_t oldest_result;

    // Operand stack model and its limit register.
    logic [31:0]        model_stack[STACK_DEPTH];
    int                 model_depth  = 0;
    bit                 model_halted = 1'b0;
    logic [LIMIT_W-1:0] model_limit  = LIMIT_RESET;

    int items_made     = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int hold_left      = 0;
    int holds_done     = 0;
    int tx_wait        = 0;
    int tx_quiet       = 0;
    int rx_wait        = 0;
    int rx_quiet       = 0;

    postfix_expression_evaluator_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_value   (top_value),
        .stack_empty (stack_empty),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Number of entries a push may fill; limits above the depth act as the depth.
    function automatic int usable_depth();
        return (model_limit > STACK_DEPTH) ? STACK_DEPTH : int'(model_limit);
    endfunction

    function automatic status_t push_operand(input logic [31:0] v);
        if (model_depth >= usable_depth())
            return STATUS_OVERFLOW;
        model_stack[model_depth] = v;
        model_depth++;
        return STATUS_OK;
    endfunction

    // Apply one character to the stack model and return the result beat it causes.
    function automatic rpn_result_t eval_char(input logic [7:0] c);
        rpn_result_t res;
        logic [31:0] lhs;
        logic [31:0] rhs;
        longint      q;
        status_t     st;
        st = STATUS_OK;
        if (model_halted)
            st = STATUS_HALTED;
        else if (c >= CHAR_ZERO && c <= CHAR_NINE)
            st = push_operand(32'(c - CHAR_ZERO));
        else if (model_depth < 2)
            st = STATUS_UNDERFLOW;
        else
        begin
            // Right operand comes off first, then the left one.
            rhs = model_stack[model_depth - 1];
            lhs = model_stack[model_depth - 2];
            model_depth -= 2;
            case (c)
                CHAR_PLUS:  st = push_operand(lhs + rhs);
                CHAR_MINUS: st = push_operand(lhs - rhs);
                CHAR_STAR:  st = push_operand(lhs * rhs);
                CHAR_SLASH, CHAR_PERCENT:
                    if (rhs == 32'd0)
                        st = STATUS_DIVZERO;
                    else
                    begin
                        // 64-bit math keeps the most negative value over -1 well defined.
                        if (c == CHAR_SLASH)
                            q = longint'($signed(lhs)) / longint'($signed(rhs));
                        else
                            q = longint'($signed(lhs)) % longint'($signed(rhs));
                        st = push_operand(q[31:0]);
                    end
                default: st = STATUS_OK;
            endcase
        end
        if (st != STATUS_OK)
            model_halted = 1'b1;
        res.top   = (model_depth == 0) ? -32'sd1 : $signed(model_stack[model_depth - 1]);
        res.empty = (model_depth == 0);
        res.st    = st;
        return res;
    endfunction

    // Queue a character for the driver together with the result it should produce.
    function automatic void send_char(input logic [7:0] c);
        if (!model_halted)
            items_made++;
        pending_chars.push_back(c);
        expected_results.push_back(eval_char(c));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Any character that is neither a digit nor one of the five operators.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_PLUS || c == CHAR_MINUS ||
               c == CHAR_STAR || c == CHAR_SLASH || c == CHAR_PERCENT)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Mostly short idle gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Well-formed random expression content that never halts the evaluator.
    task automatic run_random(input int count);
        int         i;
        int         r;
        int         k;
        int         lim;
        bit         can_push;
        bit         can_pop;
        bit         can_arith;
        logic [7:0] c;
        for (i = 0; i < count; i++)
        begin
            lim       = usable_depth();
            can_push  = model_depth < lim;
            can_pop   = model_depth >= 2;
            can_arith = can_pop && (model_depth - 2 < lim);
            if (!can_push && !can_pop)
                break;
            r = $urandom_range(0, 99);
            if (can_push && (!can_pop || r < 50))
                c = rand_digit();
            else if (!can_arith || r >= 90)
                c = noise_char();
            else
            begin
                k = $urandom_range(0, 4);
                case (k)
                    0: c = CHAR_PLUS;
                    1: c = CHAR_MINUS;
                    2: c = CHAR_STAR;
                    default:
                        if (model_stack[model_depth - 1] == 32'd0)
                            c = CHAR_STAR;
                        else
                            c = (k == 3) ? CHAR_SLASH : CHAR_PERCENT;
                endcase
            end
            send_char(c);
        end
    endtask

    // Block until every queued beat has gone in and every result has come out.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_limit = v;
    endtask

    // Input driver: offers queued characters with random gaps between beats.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                char_code <= pending_chars.pop_front();
                in_valid  <= 1'b1;
                if (tx_quiet > 0)
                begin
                    tx_quiet--;
                    tx_wait = 0;
                end
                else
                begin
                    tx_wait = pick_gap();
                    if ($urandom_range(0, 59) == 0)
                        tx_quiet = $urandom_range(20, 60);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off while the driver still has beats queued.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && results_seen >= 200 * (holds_done + 1) &&
                 pending_chars.size() > 8)
        begin
            hold_left  <= 400;
            holds_done <= holds_done + 1;
        end
    end

    // Output monitor: checks each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: top=%0d empty=%0b status=%0d",
                                 top_value, stack_empty, status);
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (top_value !== oldest_result.top || stack_empty !== oldest_result.empty ||
                        status !== oldest_result.st)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected top=%0d empty=%0b status=%0d, got top=%0d empty=%0b status=%0d",
                                     oldest_result.top, oldest_result.empty, oldest_result.st,
                                     top_value, stack_empty, status);
                    end
                end
                if (rx_quiet > 0)
                begin
                    rx_quiet--;
                    rx_wait = 0;
                end
                else
                begin
                    rx_wait = pick_gap();
                    if ($urandom_range(0, 59) == 0)
                        rx_quiet = $urandom_range(20, 60);
                end
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // Stimulus sequence and final verdict.
    initial
    begin
        string              dir_seq;
        int                 i;
        int                 phase;
        logic [LIMIT_W-1:0] lim;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Build 2^31 from digits, then divide and take the remainder of the most
        // negative value by -1, touching every operator on the way.
        dir_seq = "888888888********8*11+*01-/01-%9";
        for (i = 0; i < dir_seq.len(); i++)
            send_char(dir_seq[i]);
        // Lowest and highest character codes discard two operands each.
        send_char(8'd255);
        send_char(CHAR_ZERO + 8'd5);
        send_char(CHAR_NINE);
        send_char(8'd0);

        // Random phases, starting with the extreme limit settings.
        phase = 0;
        while (items_made < 1400)
        begin
            case (phase)
                0:       lim = 5'd31;
                1:       lim = 5'd16;
                2:       lim = 5'd0;
                3:       lim = 5'd1;
                4:       lim = 5'd2;
                5:       lim = 5'd17;
                6:       lim = 5'd15;
                default: lim = 5'($urandom_range(0, 31));
            endcase
            write_limit(lim);
            run_random($urandom_range(60, 220));
            phase++;
        end

        // End on one halting case, then show that later beats report the halt.
        write_limit(5'd16);
        case ($urandom_range(0, 2))
            0:
                while (!model_halted)
                    send_char(rand_digit());
            1:
            begin
                while (model_depth >= 2)
                    send_char(noise_char());
                send_char(noise_char());
            end
            default:
            begin
                while (model_depth >= 2)
                    send_char(noise_char());
                send_char(CHAR_ZERO + 8'($urandom_range(1, 9)));
                send_char(CHAR_ZERO);
                send_char($urandom_range(0, 1) ? CHAR_SLASH : CHAR_PERCENT);
            end
        endcase
        for (i = 0; i < 8; i++)
            send_char(8'($urandom_range(0, 255)));

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
